[design/ill_pkg.sv]
package ill_pkg;

  localparam int SLOTS_DEF      = 16;
  localparam int ELEM_WIDTH_DEF = 32;

  localparam int KIND_W    = 2;
  localparam int POS_W     = 4;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 40;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH   = 2'd0,
    KIND_POP    = 2'd1,
    KIND_INSERT = 2'd2,
    KIND_ERASE  = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  // One memory step of an operation; each operation that is not rejected runs phases A, B and C.
  typedef enum logic [3:0] {
    STEP_NONE,
    STEP_PUSH_A,
    STEP_PUSH_B,
    STEP_PUSH_C,
    STEP_POP_A,
    STEP_POP_B,
    STEP_POP_C,
    STEP_INS_A,
    STEP_INS_B,
    STEP_INS_C,
    STEP_ERA_A,
    STEP_ERA_B,
    STEP_ERA_C
  } step_e;

  typedef struct packed {
    logic    in_ready;
    logic    walk_step;
    logic    walk_end;
    logic    init_step;
    step_e   step;
    logic    res_load;
    status_e res_status;
  } cmd_t;

  typedef struct packed {
    logic init_last;
    logic walk_done;
    logic fh_zero;
    logic head_zero;
    logic tail_zero;
    logic pos_eq_count;
    logic pos_gt_count;
    logic out_free;
  } stat_t;

endpackage

[design/ill_ctrl.sv]
module ill_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [ill_pkg::KIND_W-1:0] kind_i,
  input  ill_pkg::stat_t            stat_i,
  output ill_pkg::cmd_t             cmd_o
);

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_WALK  = 3'd3;
  localparam logic [2:0] ST_A     = 3'd4;
  localparam logic [2:0] ST_B     = 3'd5;
  localparam logic [2:0] ST_C     = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]       state_q, state_d;
  ill_pkg::kind_e   kind_q, kind_d;
  ill_pkg::kind_e   op_q, op_d;
  ill_pkg::status_e status_q, status_d;

  function automatic ill_pkg::step_e step_of(ill_pkg::kind_e op, logic [1:0] phase);
    ill_pkg::step_e s;
    s = ill_pkg::STEP_NONE;
    case (op)
      ill_pkg::KIND_PUSH:   s = (phase == 2'd0) ? ill_pkg::STEP_PUSH_A :
                                (phase == 2'd1) ? ill_pkg::STEP_PUSH_B : ill_pkg::STEP_PUSH_C;
      ill_pkg::KIND_POP:    s = (phase == 2'd0) ? ill_pkg::STEP_POP_A :
                                (phase == 2'd1) ? ill_pkg::STEP_POP_B : ill_pkg::STEP_POP_C;
      ill_pkg::KIND_INSERT: s = (phase == 2'd0) ? ill_pkg::STEP_INS_A :
                                (phase == 2'd1) ? ill_pkg::STEP_INS_B : ill_pkg::STEP_INS_C;
      default:              s = (phase == 2'd0) ? ill_pkg::STEP_ERA_A :
                                (phase == 2'd1) ? ill_pkg::STEP_ERA_B : ill_pkg::STEP_ERA_C;
    endcase
    return s;
  endfunction

  always_comb begin
    state_d  = state_q;
    kind_d   = kind_q;
    op_d     = op_q;
    status_d = status_q;
    cmd_o    = '{in_ready: 1'b0, walk_step: 1'b0, walk_end: 1'b0, init_step: 1'b0,
                 step: ill_pkg::STEP_NONE, res_load: 1'b0, res_status: status_q};
    unique case (state_q)
      ST_INIT: begin
        cmd_o.init_step = 1'b1;
        if (stat_i.init_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (in_valid_i) begin
          kind_d  = ill_pkg::kind_e'(kind_i);
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        status_d = ill_pkg::STAT_OK;
        op_d     = kind_q;
        case (kind_q)
          ill_pkg::KIND_PUSH: begin
            if (stat_i.fh_zero) begin
              status_d = ill_pkg::STAT_FULL;
              state_d  = ST_DONE;
            end else begin
              state_d = ST_A;
            end
          end
          ill_pkg::KIND_POP: begin
            if (stat_i.tail_zero) begin
              status_d = ill_pkg::STAT_EMPTY;
              state_d  = ST_DONE;
            end else begin
              state_d = ST_A;
            end
          end
          ill_pkg::KIND_INSERT: begin
            if (stat_i.fh_zero) begin
              status_d = ill_pkg::STAT_FULL;
              state_d  = ST_DONE;
            end else if (stat_i.pos_eq_count) begin
              // Inserting at the count appends.
              op_d    = ill_pkg::KIND_PUSH;
              state_d = ST_A;
            end else if (stat_i.pos_gt_count) begin
              status_d = ill_pkg::STAT_RANGE;
              state_d  = ST_DONE;
            end else begin
              state_d = ST_WALK;
            end
          end
          default: begin
            if (stat_i.head_zero) begin
              status_d = ill_pkg::STAT_EMPTY;
              state_d  = ST_DONE;
            end else if (stat_i.pos_eq_count || stat_i.pos_gt_count) begin
              status_d = ill_pkg::STAT_RANGE;
              state_d  = ST_DONE;
            end else begin
              state_d = ST_WALK;
            end
          end
        endcase
      end
      ST_WALK: begin
        if (stat_i.walk_done) begin
          cmd_o.walk_end = 1'b1;
          state_d        = ST_A;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      ST_A: begin
        cmd_o.step = step_of(op_q, 2'd0);
        state_d    = ST_B;
      end
      ST_B: begin
        cmd_o.step = step_of(op_q, 2'd1);
        state_d    = ST_C;
      end
      ST_C: begin
        cmd_o.step = step_of(op_q, 2'd2);
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_INIT;
      kind_q   <= ill_pkg::KIND_PUSH;
      op_q     <= ill_pkg::KIND_PUSH;
      status_q <= ill_pkg::STAT_OK;
    end else begin
      state_q  <= state_d;
      kind_q   <= kind_d;
      op_q     <= op_d;
      status_q <= status_d;
    end
  end

endmodule

[design/ill_dp.sv]
module ill_dp #(
  parameter int SLOTS      = ill_pkg::SLOTS_DEF,
  parameter int ELEM_WIDTH = ill_pkg::ELEM_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ill_pkg::cmd_t                 cmd_i,
  output ill_pkg::stat_t                stat_o,
  input  logic                          in_valid_i,
  input  logic [ill_pkg::POS_W-1:0]     pos_i,
  input  logic [ill_pkg::VALUE_W-1:0]   value_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [ill_pkg::STATUS_W-1:0]  out_status_o,
  output logic [ill_pkg::VALUE_W-1:0]   out_popped_o
);

  localparam int LW    = $clog2(SLOTS);
  localparam int CMP_W = (LW > ill_pkg::POS_W) ? LW : ill_pkg::POS_W;
  localparam logic [LW-1:0] LAST_SLOT = LW'(SLOTS - 1);

  logic [ELEM_WIDTH-1:0] data_mem [SLOTS];
  logic [LW-1:0]         next_mem [SLOTS];
  logic [LW-1:0]         prev_mem [SLOTS];

  logic [ELEM_WIDTH-1:0] data_rd_q;
  logic [LW-1:0]         next_rd_q, prev_rd_q;

  logic [LW-1:0]         head_q, head_d, tail_q, tail_d, fh_q, fh_d, count_q, count_d;
  logic [LW-1:0]         cur_q, cur_d, slot_q, slot_d, before_q, before_d, after_q, after_d;
  logic [LW-1:0]         init_q, init_d;
  logic [ill_pkg::POS_W-1:0] pos_q, pos_d, rem_q, rem_d;
  logic                  pend_q, pend_d;
  logic [ELEM_WIDTH-1:0] val_q, val_d, popped_q, popped_d;
  logic                  out_valid_q, out_valid_d;
  logic [ill_pkg::STATUS_W-1:0] out_status_q, out_status_d;
  logic [ill_pkg::VALUE_W-1:0]  out_popped_q, out_popped_d;

  logic [LW-1:0]         cur_val;
  logic [LW-1:0]         next_raddr, prev_raddr, data_raddr;
  logic                  next_we, prev_we, data_we;
  logic [LW-1:0]         next_waddr, next_wdata, prev_waddr, prev_wdata, data_waddr;
  logic [ELEM_WIDTH-1:0] data_wdata;
  logic                  load;

  // While walking, the slot just reached is still in the read register.
  assign cur_val = pend_q ? next_rd_q : cur_q;
  assign load    = in_valid_i && cmd_i.in_ready;

  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    fh_d       = fh_q;
    count_d    = count_q;
    cur_d      = cur_q;
    slot_d     = slot_q;
    before_d   = before_q;
    after_d    = after_q;
    init_d     = init_q;
    pos_d      = pos_q;
    rem_d      = rem_q;
    pend_d     = pend_q;
    val_d      = val_q;
    popped_d   = popped_q;
    next_raddr = '0;
    prev_raddr = '0;
    data_raddr = '0;
    next_we    = 1'b0;
    next_waddr = '0;
    next_wdata = '0;
    prev_we    = 1'b0;
    prev_waddr = '0;
    prev_wdata = '0;
    data_we    = 1'b0;
    data_waddr = '0;
    data_wdata = val_q;

    if (cmd_i.init_step) begin
      next_we    = 1'b1;
      next_waddr = init_q;
      next_wdata = (init_q == LAST_SLOT || init_q == '0) ? '0 : init_q + LW'(1);
      init_d     = init_q + LW'(1);
    end

    if (load) begin
      pos_d    = pos_i;
      rem_d    = pos_i;
      val_d    = ELEM_WIDTH'(value_i);
      cur_d    = head_q;
      pend_d   = 1'b0;
      popped_d = '0;
    end

    if (cmd_i.walk_step) begin
      next_raddr = cur_val;
      cur_d      = cur_val;
      pend_d     = 1'b1;
      rem_d      = rem_q - ill_pkg::POS_W'(1);
    end
    if (cmd_i.walk_end) begin
      cur_d  = cur_val;
      pend_d = 1'b0;
    end

    case (cmd_i.step)
      ill_pkg::STEP_PUSH_A: begin
        next_raddr = fh_q;
        data_we    = 1'b1;
        data_waddr = fh_q;
        prev_we    = 1'b1;
        prev_waddr = fh_q;
        prev_wdata = tail_q;
        slot_d     = fh_q;
      end
      ill_pkg::STEP_PUSH_B: begin
        fh_d       = next_rd_q;
        next_we    = 1'b1;
        next_waddr = slot_q;
        next_wdata = '0;
      end
      ill_pkg::STEP_PUSH_C: begin
        if (head_q == '0) begin
          head_d = slot_q;
        end else begin
          next_we    = 1'b1;
          next_waddr = tail_q;
          next_wdata = slot_q;
        end
        tail_d  = slot_q;
        count_d = count_q + LW'(1);
      end
      ill_pkg::STEP_POP_A: begin
        prev_raddr = tail_q;
        data_raddr = tail_q;
        slot_d     = tail_q;
      end
      ill_pkg::STEP_POP_B: begin
        before_d   = prev_rd_q;
        popped_d   = data_rd_q;
        next_we    = 1'b1;
        next_waddr = slot_q;
        next_wdata = fh_q;
        fh_d       = slot_q;
        tail_d     = prev_rd_q;
      end
      ill_pkg::STEP_POP_C: begin
        if (before_q == '0) begin
          head_d = '0;
        end else begin
          next_we    = 1'b1;
          next_waddr = before_q;
          next_wdata = '0;
        end
        count_d = count_q - LW'(1);
      end
      ill_pkg::STEP_INS_A: begin
        next_raddr = fh_q;
        prev_raddr = cur_q;
        slot_d     = fh_q;
      end
      ill_pkg::STEP_INS_B: begin
        fh_d       = next_rd_q;
        before_d   = prev_rd_q;
        next_we    = 1'b1;
        next_waddr = slot_q;
        next_wdata = cur_q;
        data_we    = 1'b1;
        data_waddr = slot_q;
        prev_we    = 1'b1;
        prev_waddr = slot_q;
        prev_wdata = prev_rd_q;
      end
      ill_pkg::STEP_INS_C: begin
        if (before_q != '0) begin
          next_we    = 1'b1;
          next_waddr = before_q;
          next_wdata = slot_q;
        end else begin
          head_d = slot_q;
        end
        prev_we    = 1'b1;
        prev_waddr = cur_q;
        prev_wdata = slot_q;
        count_d    = count_q + LW'(1);
      end
      ill_pkg::STEP_ERA_A: begin
        prev_raddr = cur_q;
        next_raddr = cur_q;
      end
      ill_pkg::STEP_ERA_B: begin
        before_d   = prev_rd_q;
        after_d    = next_rd_q;
        next_we    = 1'b1;
        next_waddr = cur_q;
        next_wdata = fh_q;
        fh_d       = cur_q;
        if (next_rd_q != '0) begin
          prev_we    = 1'b1;
          prev_waddr = next_rd_q;
          prev_wdata = prev_rd_q;
        end else begin
          tail_d = prev_rd_q;
        end
      end
      ill_pkg::STEP_ERA_C: begin
        if (before_q != '0) begin
          next_we    = 1'b1;
          next_waddr = before_q;
          next_wdata = after_q;
        end else begin
          head_d = after_q;
        end
        count_d = count_q - LW'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_popped_d = out_popped_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_i.res_load) begin
      out_valid_d  = 1'b1;
      out_status_d = cmd_i.res_status;
      out_popped_d = ill_pkg::VALUE_W'(popped_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_waddr] <= next_wdata;
    if (prev_we) prev_mem[prev_waddr] <= prev_wdata;
    if (data_we) data_mem[data_waddr] <= data_wdata;
    next_rd_q <= next_mem[next_raddr];
    prev_rd_q <= prev_mem[prev_raddr];
    data_rd_q <= data_mem[data_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      fh_q        <= LW'(1);
      count_q     <= '0;
      init_q      <= '0;
      rem_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      fh_q        <= fh_d;
      count_q     <= count_d;
      init_q      <= init_d;
      rem_q       <= rem_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    slot_q       <= slot_d;
    before_q     <= before_d;
    after_q      <= after_d;
    pos_q        <= pos_d;
    val_q        <= val_d;
    popped_q     <= popped_d;
    out_status_q <= out_status_d;
    out_popped_q <= out_popped_d;
  end

  assign stat_o.init_last    = (init_q == LAST_SLOT);
  assign stat_o.walk_done    = (rem_q == '0);
  assign stat_o.fh_zero      = (fh_q == '0);
  assign stat_o.head_zero    = (head_q == '0);
  assign stat_o.tail_zero    = (tail_q == '0);
  assign stat_o.pos_eq_count = (CMP_W'(pos_q) == CMP_W'(count_q));
  assign stat_o.pos_gt_count = (CMP_W'(pos_q) > CMP_W'(count_q));
  assign stat_o.out_free     = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_popped_o = out_popped_q;

endmodule

[design/indexed_linked_list_engine.sv]
// Linked list engine: a store of SLOTS slots holding a doubly linked list with
// a free chain. Requests arrive on the slave stream, one result per request
// leaves on the master stream.
// Request: tuser carries the kind (push back, pop back, insert before a
// position, erase at a position); tdata carries position and value.
// Result: tdata carries the status and the value removed by pop back.
// After reset the engine builds the free chain in the link memory, with
// s_axis_tready low, and then takes one request at a time. Each request is
// checked first; a rejected one goes straight to its result. Push back, pop
// back and insert at the count then run phases A, B and C; insert and erase
// first walk the next-link memory one link read per cycle. A request is taken
// again in the cycle after its result is loaded.
// A result waits in the output register while m_axis_tready is low, and the
// next request can be accepted meanwhile; its result is held back until the
// output register is free.
module indexed_linked_list_engine #(
  parameter int SLOTS      = ill_pkg::SLOTS_DEF,
  parameter int ELEM_WIDTH = ill_pkg::ELEM_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // position [3:0], item_value [35:4], zero [39:36]
  input  logic [ill_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // kind [1:0]
  input  logic [ill_pkg::KIND_W-1:0]      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // status [1:0], popped_value [33:2], zero [39:34]
  output logic [ill_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

  ill_pkg::cmd_t  cmd;
  ill_pkg::stat_t stat;
  logic [ill_pkg::STATUS_W-1:0] out_status;
  logic [ill_pkg::VALUE_W-1:0]  out_popped;

  ill_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .kind_i     (s_axis_tuser),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ill_dp #(
    .SLOTS      (SLOTS),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_valid_i   (s_axis_tvalid),
    .pos_i        (s_axis_tdata[ill_pkg::POS_W-1:0]),
    .value_i      (s_axis_tdata[ill_pkg::POS_W +: ill_pkg::VALUE_W]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (out_status),
    .out_popped_o (out_popped)
  );

  assign s_axis_tready = cmd.in_ready;
  assign m_axis_tdata  = {{(ill_pkg::M_TDATA_W - ill_pkg::STATUS_W - ill_pkg::VALUE_W){1'b0}},
                          out_popped, out_status};

endmodule

[bench/indexed_linked_list_engine_tb.sv]
`timescale 1ns / 1ps

module indexed_linked_list_engine_tb;

  localparam int CAPACITY = ill_pkg::SLOTS_DEF - 1;
  localparam int PAD_W    = ill_pkg::S_TDATA_W - ill_pkg::POS_W - ill_pkg::VALUE_W;

  typedef struct {
    ill_pkg::kind_e                  kind;
    logic [ill_pkg::POS_W-1:0]       pos;
    logic [ill_pkg::VALUE_W-1:0]     value;
    bit                              drain;  // hold this request until every result is back
  } request_t;

  typedef struct {
    ill_pkg::status_e                status;
    logic [ill_pkg::VALUE_W-1:0]     popped;
  } outcome_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  // position [3:0], item_value [35:4], zero [39:36]
  logic [ill_pkg::S_TDATA_W-1:0]   s_axis_tdata = '0;
  // kind [1:0]
  logic [ill_pkg::KIND_W-1:0]      s_axis_tuser = ill_pkg::KIND_PUSH;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // status [1:0], popped_value [33:2], zero [39:34]
  logic [ill_pkg::M_TDATA_W-1:0]   m_axis_tdata;

  indexed_linked_list_engine u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the list store: slot 0 is the sentinel (head in next, tail in prev).
  logic [ill_pkg::VALUE_W-1:0] lst_data [ill_pkg::SLOTS_DEF];
  logic [ill_pkg::POS_W-1:0]   lst_next [ill_pkg::SLOTS_DEF];
  logic [ill_pkg::POS_W-1:0]   lst_prev [ill_pkg::SLOTS_DEF];
  logic [ill_pkg::POS_W-1:0]   lst_free;

  request_t pending_requests[$];
  outcome_t due_results[$];
  request_t cur_req;
  outcome_t want;

  int  err_count;
  int  plan_len;
  int  plan_peak;
  int  kind_tally [4];
  int  status_tally [4];
  int  drv_gap;
  int  drv_calm;
  bit  drv_offer;
  int  mon_stall;
  int  mon_calm;
  bit  mon_ready;

  function automatic void list_clear();
    for (int i = 0; i < ill_pkg::SLOTS_DEF; i++) begin
      lst_data[i] = '0;
      lst_prev[i] = '0;
      lst_next[i] = (i >= 1 && i + 1 < ill_pkg::SLOTS_DEF) ? ill_pkg::POS_W'(i + 1) : '0;
    end
    lst_free = ill_pkg::POS_W'(1);
  endfunction

  function automatic logic [ill_pkg::POS_W-1:0] list_claim(
      input logic [ill_pkg::VALUE_W-1:0] v);
    logic [ill_pkg::POS_W-1:0] s;
    s = lst_free;
    lst_free = lst_next[s];
    lst_data[s] = v;
    return s;
  endfunction

  function automatic ill_pkg::status_e list_append(input logic [ill_pkg::VALUE_W-1:0] v);
    logic [ill_pkg::POS_W-1:0] s;
    logic [ill_pkg::POS_W-1:0] tail;
    if (lst_free == 0) return ill_pkg::STAT_FULL;
    s = list_claim(v);
    tail = lst_prev[0];
    lst_next[s] = '0;
    lst_prev[s] = tail;
    if (lst_next[0] == 0) lst_next[0] = s;
    else lst_next[tail] = s;
    lst_prev[0] = s;
    return ill_pkg::STAT_OK;
  endfunction

  function automatic ill_pkg::status_e list_pop(output logic [ill_pkg::VALUE_W-1:0] v);
    logic [ill_pkg::POS_W-1:0] t;
    logic [ill_pkg::POS_W-1:0] b;
    v = '0;
    t = lst_prev[0];
    if (t == 0) return ill_pkg::STAT_EMPTY;
    v = lst_data[t];
    b = lst_prev[t];
    lst_next[t] = lst_free;
    lst_free = t;
    lst_prev[0] = b;
    if (b == 0) lst_next[0] = '0;
    else lst_next[b] = '0;
    return ill_pkg::STAT_OK;
  endfunction

  // Follows next links from the head; left holds the steps still owed at the end.
  function automatic logic [ill_pkg::POS_W-1:0] list_seek(input int pos, output int left);
    logic [ill_pkg::POS_W-1:0] at;
    int hops;
    at = lst_next[0];
    hops = 0;
    left = pos;
    while (at != 0 && left > 0 && hops < ill_pkg::SLOTS_DEF) begin
      at = lst_next[at];
      left--;
      hops++;
    end
    return at;
  endfunction

  function automatic ill_pkg::status_e list_insert(input int pos,
                                                   input logic [ill_pkg::VALUE_W-1:0] v);
    logic [ill_pkg::POS_W-1:0] at;
    logic [ill_pkg::POS_W-1:0] s;
    logic [ill_pkg::POS_W-1:0] b;
    int left;
    if (lst_free == 0) return ill_pkg::STAT_FULL;
    at = list_seek(pos, left);
    if (at == 0) begin
      if (left == 0) return list_append(v);
      return ill_pkg::STAT_RANGE;
    end
    s = list_claim(v);
    b = lst_prev[at];
    lst_next[s] = at;
    lst_prev[s] = b;
    if (b != 0) lst_next[b] = s;
    else lst_next[0] = s;
    lst_prev[at] = s;
    return ill_pkg::STAT_OK;
  endfunction

  function automatic ill_pkg::status_e list_erase(input int pos);
    logic [ill_pkg::POS_W-1:0] at;
    logic [ill_pkg::POS_W-1:0] b;
    logic [ill_pkg::POS_W-1:0] a;
    int left;
    if (lst_next[0] == 0) return ill_pkg::STAT_EMPTY;
    at = list_seek(pos, left);
    if (at == 0) return ill_pkg::STAT_RANGE;
    b = lst_prev[at];
    a = lst_next[at];
    if (b != 0) lst_next[b] = a;
    else lst_next[0] = a;
    if (a != 0) lst_prev[a] = b;
    else lst_prev[0] = b;
    lst_next[at] = lst_free;
    lst_free = at;
    return ill_pkg::STAT_OK;
  endfunction

  function automatic outcome_t list_apply(input request_t r);
    outcome_t o;
    o.popped = '0;
    case (r.kind)
      ill_pkg::KIND_PUSH:   o.status = list_append(r.value);
      ill_pkg::KIND_POP:    o.status = list_pop(o.popped);
      ill_pkg::KIND_INSERT: o.status = list_insert(int'(r.pos), r.value);
      default:              o.status = list_erase(int'(r.pos));
    endcase
    return o;
  endfunction

  // Idle cycles before the next transaction, with occasional runs of back-to-back ones.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  // Queues a request and tracks the list length it will leave behind.
  task automatic plan(input ill_pkg::kind_e k, input int p,
                      input logic [ill_pkg::VALUE_W-1:0] v, input bit drain);
    request_t r;
    r.kind = k;
    r.pos = p[ill_pkg::POS_W-1:0];
    r.value = v;
    r.drain = drain;
    pending_requests.push_back(r);
    case (k)
      ill_pkg::KIND_PUSH:   if (plan_len < CAPACITY) plan_len++;
      ill_pkg::KIND_POP:    if (plan_len > 0) plan_len--;
      ill_pkg::KIND_INSERT: if (plan_len < CAPACITY && p <= plan_len) plan_len++;
      default:              if (plan_len > 0 && p < plan_len) plan_len--;
    endcase
    if (plan_len > plan_peak) plan_peak = plan_len;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= ill_pkg::KIND_PUSH;
      drv_gap = 0;
      drv_calm = 0;
    end else begin
      drv_offer = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        want = list_apply(cur_req);
        due_results.push_back(want);
        kind_tally[cur_req.kind]++;
        status_tally[want.status]++;
        drv_offer = 1'b0;
        drv_gap = draw_wait(drv_calm);
      end
      if (!drv_offer) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (pending_requests.size() > 0 &&
                     !(pending_requests[0].drain && due_results.size() > 0)) begin
          cur_req = pending_requests.pop_front();
          s_axis_tdata <= {{PAD_W{1'b0}}, cur_req.value, cur_req.pos};
          s_axis_tuser <= cur_req.kind;
          drv_offer = 1'b1;
        end
      end
      s_axis_tvalid <= drv_offer;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      mon_stall = 0;
      mon_calm = 0;
    end else begin
      mon_ready = m_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_results.size() == 0) begin
          $error("result with no request outstanding: tdata %h", m_axis_tdata);
          err_count++;
        end else begin
          want = due_results.pop_front();
          if (m_axis_tdata[ill_pkg::STATUS_W-1:0] !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status,
                   m_axis_tdata[ill_pkg::STATUS_W-1:0]);
            err_count++;
          end
          if (m_axis_tdata[ill_pkg::STATUS_W +: ill_pkg::VALUE_W] !== want.popped) begin
            $error("popped_value: expected %h, actual %h", want.popped,
                   m_axis_tdata[ill_pkg::STATUS_W +: ill_pkg::VALUE_W]);
            err_count++;
          end
        end
        mon_stall = draw_wait(mon_calm);
        mon_ready = (mon_stall == 0);
      end else if (!m_axis_tready) begin
        if (mon_stall > 0) mon_stall--;
        mon_ready = (mon_stall == 0);
      end
      m_axis_tready <= mon_ready;
    end
  end

  initial begin
    int mode;
    int grow_share;
    int p;
    ill_pkg::kind_e k;
    logic [ill_pkg::VALUE_W-1:0] v;

    err_count = 0;
    plan_len = 0;
    plan_peak = 0;
    list_clear();

    // Empty list, the sole element, head and tail cases.
    plan(ill_pkg::KIND_POP, 0, 32'h1111_1111, 1'b0);
    plan(ill_pkg::KIND_ERASE, 0, 32'h0, 1'b0);
    plan(ill_pkg::KIND_INSERT, 1, 32'hDEAD_BEEF, 1'b0);
    plan(ill_pkg::KIND_INSERT, 0, 32'h0000_0000, 1'b0);
    plan(ill_pkg::KIND_ERASE, 0, 32'h0, 1'b0);
    plan(ill_pkg::KIND_PUSH, 0, 32'hFFFF_FFFF, 1'b0);
    plan(ill_pkg::KIND_INSERT, 0, 32'h0000_0000, 1'b0);
    plan(ill_pkg::KIND_ERASE, 1, 32'h0, 1'b0);
    plan(ill_pkg::KIND_POP, 15, 32'h0, 1'b0);
    // Fill the store through inserts at head, middle and end.
    while (plan_len < CAPACITY)
      plan(ill_pkg::KIND_INSERT, $urandom_range(0, plan_len), $urandom, 1'b0);
    plan(ill_pkg::KIND_PUSH, 0, 32'hA5A5_A5A5, 1'b0);
    plan(ill_pkg::KIND_INSERT, 15, 32'h5A5A_5A5A, 1'b0);
    plan(ill_pkg::KIND_ERASE, 15, 32'h0, 1'b0);
    plan(ill_pkg::KIND_ERASE, 14, 32'h0, 1'b0);

    mode = 0;
    for (int i = 0; i < 750; i++) begin
      if (i % 40 == 0) mode = $urandom_range(0, 2);
      grow_share = (mode == 0) ? 75 : (mode == 1) ? 25 : 50;
      v = $urandom;
      if ($urandom_range(0, 15) == 0) v = $urandom_range(0, 1) ? '1 : '0;
      if ($urandom_range(0, 99) < 8) begin
        k = ill_pkg::kind_e'($urandom_range(0, 3));
        p = $urandom_range(0, 15);
      end else begin
        if ($urandom_range(0, 99) < grow_share)
          k = $urandom_range(0, 1) ? ill_pkg::KIND_PUSH : ill_pkg::KIND_INSERT;
        else
          k = $urandom_range(0, 1) ? ill_pkg::KIND_POP : ill_pkg::KIND_ERASE;
        if (k == ill_pkg::KIND_INSERT) p = $urandom_range(0, plan_len);
        else if (plan_len > 0) p = $urandom_range(0, plan_len - 1);
        else p = $urandom_range(0, 15);
      end
      plan(k, p, v, (i == 0) || (i == 375));
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_requests.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Requests: %0d push back, %0d pop back, %0d insert, %0d erase;",
             kind_tally[ill_pkg::KIND_PUSH], kind_tally[ill_pkg::KIND_POP],
             kind_tally[ill_pkg::KIND_INSERT], kind_tally[ill_pkg::KIND_ERASE]);
    $display("list held up to %0d; %0d ok, %0d full, %0d empty, %0d out of range; %0d mismatches.",
             plan_peak, status_tally[ill_pkg::STAT_OK], status_tally[ill_pkg::STAT_FULL],
             status_tally[ill_pkg::STAT_EMPTY], status_tally[ill_pkg::STAT_RANGE], err_count);
    if (err_count == 0) begin
      $display("PASS indexed_linked_list_engine");
    end else begin
      $display("FAIL indexed_linked_list_engine");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d requests queued and %0d results outstanding.",
             pending_requests.size(), due_results.size());
    $display("FAIL indexed_linked_list_engine");
    $finish;
  end

endmodule

[sim.f]
design/ill_pkg.sv
design/ill_ctrl.sv
design/ill_dp.sv
design/indexed_linked_list_engine.sv
bench/indexed_linked_list_engine_tb.sv
